>>> design/ibs_pkg.sv
package ibs_pkg;

    // Default array sizes
    localparam int MAX_SPINS_DEF    = 32;
    localparam int MAX_REPLICAS_DEF = 4;

    // Command codes
    localparam logic [1:0] CMD_LOAD_COUPLING = 2'd0;
    localparam logic [1:0] CMD_LOAD_STATE    = 2'd1;
    localparam logic [1:0] CMD_RUN           = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_COUPLING_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_FINAL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIN_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLICA_COUNT = 3'd5;

endpackage

>>> design/ising_bifurcation_solver.sv
// Ballistic simulated-bifurcation Ising solver. Load the coupling matrix (command 0) and
// the initial position and momentum of each replica's spins (command 1); a load
// transaction does not stall the input. A run transaction (command 2) first divides the
// final pump by the step count in a bit-serial restoring divider, then performs
// step_count symplectic Euler steps, and finally emits one result per replica in use,
// carrying the spin signs. Everything runs on a single shared 38x21 signed multiplier
// under a small sequencer, with one read port and one write port per store: the force
// pass steps through a read, a multiply and an accumulate state per multiply-accumulate,
// and the update pass feeds seven products per spin through the multiplier. The input
// is not ready during a run. Configuration may be written only while the block is idle;
// the stores are undefined until loaded.
module ising_bifurcation_solver #(
    parameter int MAX_SPINS    = ibs_pkg::MAX_SPINS_DEF,
    parameter int MAX_REPLICAS = ibs_pkg::MAX_REPLICAS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ibs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ibs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_command,
    input  logic [4:0]                    i_row,
    input  logic [4:0]                    i_col,
    input  logic signed [15:0]            i_coupling,
    input  logic [1:0]                    i_replica,
    input  logic [4:0]                    i_spin_index,
    input  logic signed [15:0]            i_init_position,
    input  logic signed [15:0]            i_init_momentum,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_out_replica,
    output logic [31:0]                   o_spins,
    output logic                          o_last
);

    localparam int PAW = $clog2(MAX_REPLICAS * MAX_SPINS);
    localparam int CAW = $clog2(MAX_SPINS * MAX_SPINS);
    localparam int SW  = $clog2(MAX_SPINS);
    localparam int RW  = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
    localparam int NW  = $clog2(MAX_SPINS + 1);
    localparam int KW  = $clog2(MAX_REPLICAS + 1);

    // Sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DIV      = 5'd1;
    localparam logic [4:0] S_STEP_CHK = 5'd2;
    localparam logic [4:0] S_F_RD     = 5'd3;
    localparam logic [4:0] S_F_MUL    = 5'd4;
    localparam logic [4:0] S_F_ACC    = 5'd5;
    localparam logic [4:0] S_U_RD     = 5'd6;
    localparam logic [4:0] S_U_M1     = 5'd7;
    localparam logic [4:0] S_U_M2     = 5'd8;
    localparam logic [4:0] S_U_M3     = 5'd9;
    localparam logic [4:0] S_U_S      = 5'd10;
    localparam logic [4:0] S_U_M4     = 5'd11;
    localparam logic [4:0] S_U_M5     = 5'd12;
    localparam logic [4:0] S_U_Y      = 5'd13;
    localparam logic [4:0] S_U_M6     = 5'd14;
    localparam logic [4:0] S_U_M7     = 5'd15;
    localparam logic [4:0] S_U_X      = 5'd16;
    localparam logic [4:0] S_PUMP     = 5'd17;
    localparam logic [4:0] S_OUT_RD   = 5'd18;
    localparam logic [4:0] S_OUT_BIT  = 5'd19;
    localparam logic [4:0] S_OUT_EMIT = 5'd20;

    localparam logic signed [39:0] YMAX = 40'sd524287;
    localparam logic signed [39:0] YMIN = -40'sd524288;
    localparam logic signed [31:0] XONE = 32'sd16384;

    // Configuration registers
    logic [15:0] r_gain, r_pf, r_dt, r_steps;
    logic [5:0]  r_spin_cnt;
    logic [2:0]  r_rep_cnt;

    // Sequencer
    logic [4:0]  r_state;
    logic [NW-1:0] r_n;
    logic [KW-1:0] r_k;
    logic [RW-1:0] r_r;
    logic [SW-1:0] r_j, r_i;
    logic [15:0] r_stepc;
    logic [31:0] r_pump, r_inc;
    logic [31:0] r_dq;
    logic [16:0] r_rem;
    logic [4:0]  r_dcnt;
    logic signed [39:0] r_acc;
    logic signed [63:0] r_part, r_s;
    logic signed [19:0] r_ynew;
    logic [31:0] r_bits;

    // Shared multiplier
    logic signed [37:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [58:0] r_prod;

    // Stores
    logic signed [15:0] cpl_mem [MAX_SPINS*MAX_SPINS];
    logic signed [15:0] pos_mem [MAX_REPLICAS*MAX_SPINS];
    logic signed [19:0] mom_mem [MAX_REPLICAS*MAX_SPINS];
    logic signed [39:0] frc_mem [MAX_REPLICAS*MAX_SPINS];
    logic signed [15:0] r_cpl_q, r_pos_q;
    logic signed [19:0] r_mom_q;
    logic signed [39:0] r_frc_q;

    function automatic logic [PAW-1:0] f_pa(input int rr, input int ss);
        return PAW'(rr * MAX_SPINS + ss);
    endfunction

    function automatic logic [CAW-1:0] f_ca(input int rr, input int cc);
        return CAW'(rr * MAX_SPINS + cc);
    endfunction

    logic in_acc;
    logic i_last, j_last, r_last;
    logic n_zero, k_zero;
    assign in_acc = i_in_valid && o_in_ready;
    assign i_last = (int'(r_i) == int'(r_n) - 1);
    assign j_last = (int'(r_j) == int'(r_n) - 1);
    assign r_last = (int'(r_r) == int'(r_k) - 1);
    assign n_zero = (r_n == '0);
    assign k_zero = (r_k == '0);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Divider step
    logic [16:0] div_trial;
    logic        div_bit;
    assign div_trial = {r_rem[15:0], r_dq[31]};
    assign div_bit   = (div_trial >= {1'b0, r_steps});

    // Update datapath
    logic signed [33:0] diff;
    logic signed [47:0] t_val;
    logic signed [65:0] dyfull, dys;
    logic signed [39:0] ysum;
    logic signed [58:0] dxs;
    logic signed [31:0] xs;
    logic               x_over;
    logic signed [39:0] acc_next;

    assign diff   = $signed({2'b00, r_pf, 16'h0000}) - $signed({2'b00, r_pump});
    assign t_val  = r_s[63:16];
    assign dyfull = (66'(r_prod) <<< 20) + 66'(r_part);
    assign dys    = dyfull >>> 28;
    assign ysum   = 40'(r_mom_q) + $signed(dys[39:0]);
    assign dxs    = r_prod >>> 28;
    assign xs     = 32'(r_pos_q) + $signed(dxs[31:0]);
    assign x_over = (xs > XONE) || (xs < -XONE);
    assign acc_next = r_acc + 40'(r_prod);

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_F_MUL: begin
                mul_a = 38'(r_pos_q);
                mul_b = 21'(r_cpl_q);
            end
            S_U_M1: begin
                mul_a = $signed({22'd0, r_gain});
                mul_b = $signed({1'b0, r_frc_q[19:0]});
            end
            S_U_M2: begin
                mul_a = $signed({22'd0, r_gain});
                mul_b = 21'($signed(r_frc_q[39:20]));
            end
            S_U_M3: begin
                mul_a = 38'(diff);
                mul_b = 21'(r_pos_q);
            end
            S_U_M4: begin
                mul_a = $signed({18'd0, t_val[19:0]});
                mul_b = $signed({5'd0, r_dt});
            end
            S_U_M5: begin
                mul_a = 38'($signed(t_val[47:20]));
                mul_b = $signed({5'd0, r_dt});
            end
            S_U_M6: begin
                mul_a = 38'(r_ynew);
                mul_b = $signed({5'd0, r_pf});
            end
            S_U_M7: begin
                mul_a = r_prod[37:0];
                mul_b = $signed({5'd0, r_dt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Memory ports
    logic            cpl_we, pos_we, frc_we;
    logic [CAW-1:0]  cpl_wa, cpl_ra;
    logic [PAW-1:0]  pos_wa, pos_ra, ld_pa, rj_pa;
    logic signed [15:0] pos_wd;
    logic signed [19:0] mom_wd;

    assign ld_pa  = f_pa(int'(i_replica), int'(i_spin_index));
    assign rj_pa  = f_pa(int'(r_r), int'(r_j));
    assign cpl_we = in_acc && (i_command == ibs_pkg::CMD_LOAD_COUPLING)
                    && (int'(i_row) < MAX_SPINS) && (int'(i_col) < MAX_SPINS);
    assign cpl_wa = f_ca(int'(i_row), int'(i_col));
    assign cpl_ra = f_ca(int'(r_i), int'(r_j));
    assign pos_ra = (r_state == S_F_RD) ? f_pa(int'(r_r), int'(r_i)) : rj_pa;
    assign frc_we = (r_state == S_F_ACC) && i_last;

    always_comb begin
        pos_we = 1'b0;
        pos_wa = ld_pa;
        pos_wd = i_init_position;
        mom_wd = 20'(i_init_momentum);
        if (r_state == S_U_X) begin
            pos_we = 1'b1;
            pos_wa = rj_pa;
            if (x_over) begin
                pos_wd = xs[31] ? -16'sd16384 : 16'sd16384;
                mom_wd = '0;
            end else begin
                pos_wd = xs[15:0];
                mom_wd = r_ynew;
            end
        end else if (in_acc && (i_command == ibs_pkg::CMD_LOAD_STATE)
                     && (int'(i_replica) < MAX_REPLICAS)
                     && (int'(i_spin_index) < MAX_SPINS)) begin
            pos_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cpl_we) begin
            cpl_mem[cpl_wa] <= i_coupling;
        end
        r_cpl_q <= cpl_mem[cpl_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
            mom_mem[pos_wa] <= mom_wd;
        end
        r_pos_q <= pos_mem[pos_ra];
        r_mom_q <= mom_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (frc_we) begin
            frc_mem[rj_pa] <= acc_next;
        end
        r_frc_q <= frc_mem[rj_pa];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= 16'd4096;
            r_pf       <= 16'd4096;
            r_dt       <= 16'd6554;
            r_steps    <= 16'd10000;
            r_spin_cnt <= 6'd32;
            r_rep_cnt  <= 3'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ibs_pkg::CFG_COUPLING_GAIN: r_gain     <= i_cfg_data;
                ibs_pkg::CFG_PUMP_FINAL:    r_pf       <= i_cfg_data;
                ibs_pkg::CFG_TIME_STEP:     r_dt       <= i_cfg_data;
                ibs_pkg::CFG_STEP_COUNT:    r_steps    <= i_cfg_data;
                ibs_pkg::CFG_SPIN_COUNT:    r_spin_cnt <= i_cfg_data[5:0];
                ibs_pkg::CFG_REPLICA_COUNT: r_rep_cnt  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_pump      <= '0;
            r_inc       <= '0;
            r_stepc     <= '0;
            r_r         <= '0;
            r_j         <= '0;
            r_i         <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_dcnt      <= '0;
        end else begin
            // drop a taken result unless the emit state reloads it this cycle
            if (o_out_valid && i_out_ready && (r_state != S_OUT_EMIT)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_command == ibs_pkg::CMD_RUN)) begin
                        r_n     <= (int'(r_spin_cnt) > MAX_SPINS) ? NW'(MAX_SPINS)
                                                                  : NW'(r_spin_cnt);
                        r_k     <= (int'(r_rep_cnt) > MAX_REPLICAS) ? KW'(MAX_REPLICAS)
                                                                   : KW'(r_rep_cnt);
                        r_pump  <= '0;
                        r_stepc <= '0;
                        r_dq    <= {r_pf, 16'h0000};
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // one quotient bit per cycle, restoring
                    r_rem  <= div_bit ? (div_trial - {1'b0, r_steps}) : div_trial;
                    r_dq   <= {r_dq[30:0], div_bit};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_inc   <= {r_dq[30:0], div_bit};
                        r_state <= S_STEP_CHK;
                    end
                end
                S_STEP_CHK: begin
                    r_r <= '0;
                    r_j <= '0;
                    r_i <= '0;
                    r_acc <= '0;
                    r_bits <= '0;
                    if (r_stepc == r_steps) begin
                        if (k_zero) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= n_zero ? S_OUT_EMIT : S_OUT_RD;
                        end
                    end else if (k_zero || n_zero) begin
                        r_state <= S_PUMP;
                    end else begin
                        r_state <= S_F_RD;
                    end
                end
                // force pass: f[r][j] = sum_i x[r][i] * J[i][j]
                S_F_RD:  r_state <= S_F_MUL;
                S_F_MUL: r_state <= S_F_ACC;
                S_F_ACC: begin
                    r_state <= S_F_RD;
                    if (i_last) begin
                        r_acc <= '0;
                        r_i   <= '0;
                        if (j_last) begin
                            r_j <= '0;
                            if (r_last) begin
                                r_r     <= '0;
                                r_state <= S_U_RD;
                            end else begin
                                r_r <= r_r + RW'(1);
                            end
                        end else begin
                            r_j <= r_j + SW'(1);
                        end
                    end else begin
                        r_acc <= acc_next;
                        r_i   <= r_i + SW'(1);
                    end
                end
                // update pass: momentum, then position
                S_U_RD:  r_state <= S_U_M1;
                S_U_M1:  r_state <= S_U_M2;
                S_U_M2: begin
                    r_part  <= 64'(r_prod);
                    r_state <= S_U_M3;
                end
                S_U_M3: begin
                    r_part  <= r_part + (64'(r_prod) <<< 20);
                    r_state <= S_U_S;
                end
                S_U_S: begin
                    r_s     <= (r_part <<< 5) - 64'(r_prod);
                    r_state <= S_U_M4;
                end
                S_U_M4:  r_state <= S_U_M5;
                S_U_M5: begin
                    r_part  <= 64'(r_prod);
                    r_state <= S_U_Y;
                end
                S_U_Y: begin
                    if (ysum > YMAX) begin
                        r_ynew <= YMAX[19:0];
                    end else if (ysum < YMIN) begin
                        r_ynew <= YMIN[19:0];
                    end else begin
                        r_ynew <= ysum[19:0];
                    end
                    r_state <= S_U_M6;
                end
                S_U_M6:  r_state <= S_U_M7;
                S_U_M7:  r_state <= S_U_X;
                S_U_X: begin
                    r_state <= S_U_RD;
                    if (j_last) begin
                        r_j <= '0;
                        if (r_last) begin
                            r_r     <= '0;
                            r_state <= S_PUMP;
                        end else begin
                            r_r <= r_r + RW'(1);
                        end
                    end else begin
                        r_j <= r_j + SW'(1);
                    end
                end
                S_PUMP: begin
                    r_pump  <= r_pump + r_inc;
                    r_stepc <= r_stepc + 16'd1;
                    r_state <= S_STEP_CHK;
                end
                // report: gather sign bits of one replica, then emit
                S_OUT_RD: r_state <= S_OUT_BIT;
                S_OUT_BIT: begin
                    r_bits <= r_bits | (32'(!r_pos_q[15]) << r_j);
                    if (j_last) begin
                        r_state <= S_OUT_EMIT;
                    end else begin
                        r_j     <= r_j + SW'(1);
                        r_state <= S_OUT_RD;
                    end
                end
                S_OUT_EMIT: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid   <= 1'b1;
                        o_out_replica <= 2'(r_r);
                        o_spins       <= r_bits;
                        o_last        <= r_last;
                        r_bits        <= '0;
                        r_j           <= '0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_r     <= r_r + RW'(1);
                            r_state <= n_zero ? S_OUT_EMIT : S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/ibs_checker.sv
module ibs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [1:0]                    i_command,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [1:0]                    o_out_replica,
    input logic [31:0]                   o_spins,
    input logic                          o_last
);

    // Hold a pending result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_spins)
            && $stable(o_out_replica) && $stable(o_last))
        else $error("result changed while stalled");

    // A run transaction makes the block busy
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == ibs_pkg::CMD_RUN) |=> !o_in_ready)
        else $error("block ready right after a run was accepted");

    // Loads do not stall the input
    a_load_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_command == ibs_pkg::CMD_LOAD_COUPLING
            || i_command == ibs_pkg::CMD_LOAD_STATE) |=> o_in_ready)
        else $error("load transaction stalled the input");

    // Reset drops any result
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind ising_bifurcation_solver ibs_checker u_ibs_checker (.*);
